// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros shared by the rtl
// clocked property checks, disabled while the active-low reset is asserted
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_PROP(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("%m: property failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("%m: forbidden condition seen");

`endif

// ===== rtl/core/xsmr_pkg.sv =====
// ----------------------------------------------------------------------------
// xsmr_pkg
// shared types and constants of the xml subset message recognizer
// ----------------------------------------------------------------------------
package xsmr_pkg;

    // message buffer depth and derived field widths
    localparam int BUF_DEPTH = 8192;
    localparam int INDEX_W   = 13;
    localparam int LENGTH_W  = 14;

    typedef enum logic {
        OP_DATA  = 1'b0,
        OP_FLUSH = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_DONE    = 2'd1,
        ST_SYNTAX  = 2'd2,
        ST_OVERRUN = 2'd3
    } status_t;

    // byte classes seen by the grammar
    typedef enum logic [3:0] {
        CL_OTHER,
        CL_LETTER,
        CL_SPACE,
        CL_WHITE,
        CL_LT,
        CL_GT,
        CL_SLASH,
        CL_EQ,
        CL_QUOTE
    } class_t;

    typedef struct packed {
        opcode_t    opcode;
        logic [7:0] data_byte;
        class_t     cls;
    } item_t;

endpackage

// ===== rtl/core/xsmr_front.sv =====
// ----------------------------------------------------------------------------
// xsmr_front
// accepts input transactions, classifies the byte and registers the item
// ----------------------------------------------------------------------------
module xsmr_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_opcode,
    input  logic [7:0]           s_data_byte,
    output logic                 f_valid,
    input  logic                 f_ready,
    output xsmr_pkg::item_t      f_item
);

    logic                  valid_reg;
    logic                  valid_next;
    xsmr_pkg::item_t       item_reg;
    xsmr_pkg::item_t       item_next;
    xsmr_pkg::class_t      cls;

    // byte classification
    always_comb begin
        if (s_data_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
            cls = xsmr_pkg::CL_LETTER;
        end else if (s_data_byte == 8'h20) begin
            cls = xsmr_pkg::CL_SPACE;
        end else if (s_data_byte inside {[8'h09:8'h0D]}) begin
            cls = xsmr_pkg::CL_WHITE;
        end else if (s_data_byte == 8'h3C) begin
            cls = xsmr_pkg::CL_LT;
        end else if (s_data_byte == 8'h3E) begin
            cls = xsmr_pkg::CL_GT;
        end else if (s_data_byte == 8'h2F) begin
            cls = xsmr_pkg::CL_SLASH;
        end else if (s_data_byte == 8'h3D) begin
            cls = xsmr_pkg::CL_EQ;
        end else if (s_data_byte == 8'h22) begin
            cls = xsmr_pkg::CL_QUOTE;
        end else begin
            cls = xsmr_pkg::CL_OTHER;
        end
    end

    assign s_ready = !valid_reg || f_ready;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_ready) begin
            valid_next = s_valid;
            if (s_valid) begin
                item_next.opcode    = xsmr_pkg::opcode_t'(s_opcode);
                item_next.data_byte = s_data_byte;
                item_next.cls       = cls;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign f_valid = valid_reg;
    assign f_item  = item_reg;

endmodule

// ===== rtl/core/xsmr_queue.sv =====
// ----------------------------------------------------------------------------
// xsmr_queue
// two-entry queue of classified items between front and back
// ----------------------------------------------------------------------------
module xsmr_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  xsmr_pkg::item_t      wr_item,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output xsmr_pkg::item_t      rd_item
);

    xsmr_pkg::item_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            push;
    logic            pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_item  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== rtl/core/xsmr_back.sv =====
// ----------------------------------------------------------------------------
// xsmr_back
// grammar state machine, byte counter and registered result stage
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xsmr_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    output logic                              q_ready,
    input  xsmr_pkg::item_t                   q_item,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_store_valid,
    output logic [xsmr_pkg::INDEX_W-1:0]      m_store_index,
    output logic [7:0]                        m_store_byte,
    output logic [1:0]                        m_status,
    output logic [xsmr_pkg::LENGTH_W-1:0]     m_message_length
);

    typedef enum logic [4:0] {
        S_WAIT    = 5'd0,
        S_TAG1    = 5'd1,
        S_TAG     = 5'd2,
        S_ASTART  = 5'd3,
        S_ANAME   = 5'd4,
        S_VFIRST  = 5'd5,
        S_VQ      = 5'd6,
        S_AFTERQ  = 5'd7,
        S_VU      = 5'd8,
        S_SUBOPEN = 5'd9,
        S_SUBFST  = 5'd10,
        S_STAG    = 5'd11,
        S_SASTART = 5'd12,
        S_SANAME  = 5'd13,
        S_SVFIRST = 5'd14,
        S_SVQ     = 5'd15,
        S_SAFTERQ = 5'd16,
        S_SVU     = 5'd17,
        S_SSLASH  = 5'd18,
        S_PCLOSE  = 5'd19,
        S_PSLASH  = 5'd20,
        S_DONE    = 5'd21,
        S_ERR     = 5'd22,
        S_OVR     = 5'd23
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [xsmr_pkg::LENGTH_W-1:0]   count_reg;
    logic [xsmr_pkg::LENGTH_W-1:0]   count_next;
    logic                            valid_reg;
    logic                            valid_next;
    logic                            store_valid_reg;
    logic                            store_valid_next;
    logic [xsmr_pkg::INDEX_W-1:0]    store_index_reg;
    logic [xsmr_pkg::INDEX_W-1:0]    store_index_next;
    logic [7:0]                      store_byte_reg;
    logic [7:0]                      store_byte_next;
    xsmr_pkg::status_t               status_reg;
    xsmr_pkg::status_t               status_next;
    logic [xsmr_pkg::LENGTH_W-1:0]   length_reg;
    logic [xsmr_pkg::LENGTH_W-1:0]   length_next;

    state_t                          nx;
    logic                            store;
    logic                            err;
    logic                            is_white;
    logic [xsmr_pkg::LENGTH_W-1:0]   base;
    logic                            pop;
    logic                            flush;

    assign q_ready  = !valid_reg || m_ready;
    assign pop      = q_valid && q_ready;
    assign flush    = (q_item.opcode == xsmr_pkg::OP_FLUSH);
    assign is_white = (q_item.cls == xsmr_pkg::CL_SPACE) ||
                      (q_item.cls == xsmr_pkg::CL_WHITE);

    // grammar transition for one data byte
    always_comb begin
        nx    = state_reg;
        store = 1'b1;
        err   = 1'b0;
        case (state_reg)
            S_WAIT: begin
                if (q_item.cls == xsmr_pkg::CL_LT) nx = S_TAG1;
                else store = 1'b0;
            end
            S_TAG1: begin
                if (q_item.cls == xsmr_pkg::CL_LETTER) nx = S_TAG;
                else err = 1'b1;
            end
            S_TAG: begin
                case (q_item.cls)
                    xsmr_pkg::CL_LETTER: nx = S_TAG;
                    xsmr_pkg::CL_SLASH:  nx = S_PSLASH;
                    xsmr_pkg::CL_SPACE:  nx = S_ASTART;
                    xsmr_pkg::CL_GT:     nx = S_SUBOPEN;
                    default:             err = 1'b1;
                endcase
            end
            S_ASTART, S_SASTART: begin
                if (is_white) store = 1'b0;
                else if (q_item.cls == xsmr_pkg::CL_LETTER)
                    nx = (state_reg == S_ASTART) ? S_ANAME : S_SANAME;
                else err = 1'b1;
            end
            S_ANAME, S_SANAME: begin
                if (q_item.cls == xsmr_pkg::CL_LETTER) nx = state_reg;
                else if (q_item.cls == xsmr_pkg::CL_EQ)
                    nx = (state_reg == S_ANAME) ? S_VFIRST : S_SVFIRST;
                else err = 1'b1;
            end
            S_VFIRST: nx = (q_item.cls == xsmr_pkg::CL_QUOTE) ? S_VQ : S_VU;
            S_SVFIRST: nx = (q_item.cls == xsmr_pkg::CL_QUOTE) ? S_SVQ : S_SVU;
            S_VQ: begin
                if (q_item.cls == xsmr_pkg::CL_QUOTE) nx = S_AFTERQ;
            end
            S_SVQ: begin
                if (q_item.cls == xsmr_pkg::CL_QUOTE) nx = S_SAFTERQ;
            end
            S_AFTERQ: begin
                case (q_item.cls)
                    xsmr_pkg::CL_SLASH: nx = S_PSLASH;
                    xsmr_pkg::CL_GT:    nx = S_SUBOPEN;
                    xsmr_pkg::CL_SPACE: nx = S_ASTART;
                    default:            err = 1'b1;
                endcase
            end
            S_VU: begin
                case (q_item.cls)
                    xsmr_pkg::CL_SLASH: nx = S_PSLASH;
                    xsmr_pkg::CL_GT:    nx = S_SUBOPEN;
                    xsmr_pkg::CL_SPACE: nx = S_ASTART;
                    default:            nx = S_VU;
                endcase
            end
            S_SUBOPEN: begin
                if (q_item.cls == xsmr_pkg::CL_LT) nx = S_SUBFST;
                else err = 1'b1;
            end
            S_SUBFST: begin
                if (q_item.cls == xsmr_pkg::CL_SLASH) nx = S_PCLOSE;
                else if (q_item.cls == xsmr_pkg::CL_LETTER) nx = S_STAG;
                else err = 1'b1;
            end
            S_STAG: begin
                case (q_item.cls)
                    xsmr_pkg::CL_LETTER: nx = S_STAG;
                    xsmr_pkg::CL_SPACE:  nx = S_SASTART;
                    xsmr_pkg::CL_SLASH:  nx = S_SSLASH;
                    default:             err = 1'b1;
                endcase
            end
            S_SAFTERQ: begin
                case (q_item.cls)
                    xsmr_pkg::CL_SLASH: nx = S_SSLASH;
                    xsmr_pkg::CL_SPACE: nx = S_SASTART;
                    default:            err = 1'b1;
                endcase
            end
            S_SVU: begin
                case (q_item.cls)
                    xsmr_pkg::CL_SLASH: nx = S_SSLASH;
                    xsmr_pkg::CL_SPACE: nx = S_SASTART;
                    xsmr_pkg::CL_GT:    err = 1'b1;
                    default:            nx = S_SVU;
                endcase
            end
            S_SSLASH: begin
                if (q_item.cls == xsmr_pkg::CL_GT) nx = S_SUBOPEN;
                else err = 1'b1;
            end
            S_PCLOSE: begin
                if (q_item.cls == xsmr_pkg::CL_GT) nx = S_DONE;
            end
            S_PSLASH: begin
                if (q_item.cls == xsmr_pkg::CL_GT) nx = S_DONE;
                else err = 1'b1;
            end
            S_DONE, S_OVR: begin
                store = 1'b0;
                nx    = S_OVR;
            end
            default: begin
                store = 1'b0;
                nx    = S_ERR;
            end
        endcase
    end

    // apply flush, error, buffer limit and build the result
    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        valid_next       = valid_reg;
        store_valid_next = store_valid_reg;
        store_index_next = store_index_reg;
        store_byte_next  = store_byte_reg;
        status_next      = status_reg;
        length_next      = length_reg;
        base             = (state_reg == S_WAIT) ? '0 : count_reg;

        if (q_ready) begin
            valid_next = q_valid;
        end
        if (pop) begin
            store_valid_next = 1'b0;
            store_index_next = '0;
            store_byte_next  = '0;
            status_next      = xsmr_pkg::ST_IDLE;
            length_next      = '0;
            if (flush) begin
                state_next = S_WAIT;
                count_next = '0;
            end else begin
                state_next = nx;
                count_next = base;
                if (err) begin
                    state_next = S_ERR;
                end else if (store &&
                             base >= xsmr_pkg::LENGTH_W'(xsmr_pkg::BUF_DEPTH)) begin
                    state_next = S_OVR;
                end else if (store) begin
                    store_valid_next = 1'b1;
                    store_index_next = base[xsmr_pkg::INDEX_W-1:0];
                    store_byte_next  = q_item.data_byte;
                    count_next       = base + xsmr_pkg::LENGTH_W'(1);
                end
                case (state_next)
                    S_ERR:   status_next = xsmr_pkg::ST_SYNTAX;
                    S_OVR:   status_next = xsmr_pkg::ST_OVERRUN;
                    S_DONE:  status_next = xsmr_pkg::ST_DONE;
                    default: status_next = xsmr_pkg::ST_IDLE;
                endcase
                if (state_next == S_DONE) begin
                    length_next = count_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_WAIT;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
        store_valid_reg <= store_valid_next;
        store_index_reg <= store_index_next;
        store_byte_reg  <= store_byte_next;
        status_reg      <= status_next;
        length_reg      <= length_next;
    end

    assign m_valid          = valid_reg;
    assign m_store_valid    = store_valid_reg;
    assign m_store_index    = store_index_reg;
    assign m_store_byte     = store_byte_reg;
    assign m_status         = status_reg;
    assign m_message_length = length_reg;

    `ASSERT_PROP(a_done_has_length, aclk, aresetn,
        (valid_reg && status_reg == xsmr_pkg::ST_DONE) |-> (length_reg != '0))
    `ASSERT_PROP(a_flush_clears, aclk, aresetn,
        (pop && flush) |=> (state_reg == S_WAIT && count_reg == '0))
    `ASSERT_PROP(a_after_done_overrun, aclk, aresetn,
        (pop && !flush && state_reg == S_DONE) |=> (state_reg == S_OVR))
    `ASSERT_NEVER(a_count_in_range, aclk, aresetn,
        count_reg > xsmr_pkg::LENGTH_W'(xsmr_pkg::BUF_DEPTH))

endmodule

// ===== rtl/core/xml_subset_message_recognizer.sv =====
// ----------------------------------------------------------------------------
// xml_subset_message_recognizer
// byte-serial recognizer for one message of a restricted xml subset
// ----------------------------------------------------------------------------
// every input transaction (a data byte or a flush) gives exactly one result
// transaction. a data byte that belongs to the message comes back with its
// buffer index so the caller can store it; bytes before the opening '<' and
// whitespace before an attribute name come back with no store. the result
// that ends the message reports status complete and the message length.
// grammar violations report syntax error and bytes after completion or past
// the buffer depth report overrun; both stick until a flush. the block takes
// one transaction per cycle sustained while the result channel is not
// stalled; the grammar step in the back end is combinational. the result
// transaction for a byte passes the front register, the queue and the result
// register before it is offered.
module xml_subset_message_recognizer (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_opcode,
    input  logic [7:0]                        s_data_byte,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_store_valid,
    output logic [xsmr_pkg::INDEX_W-1:0]      m_store_index,
    output logic [7:0]                        m_store_byte,
    output logic [1:0]                        m_status,
    output logic [xsmr_pkg::LENGTH_W-1:0]     m_message_length
);

    // front to queue
    logic                f_valid;
    logic                f_ready;
    xsmr_pkg::item_t     f_item;
    // queue to back
    logic                q_valid;
    logic                q_ready;
    xsmr_pkg::item_t     q_item;

    // front end: accepts the transaction and classifies the byte
    xsmr_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_data_byte (s_data_byte),
        .f_valid     (f_valid),
        .f_ready     (f_ready),
        .f_item      (f_item)
    );

    // short queue so front and back stall independently
    xsmr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    // back end: grammar state machine, byte counter, result register
    xsmr_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_item           (q_item),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_store_valid    (m_store_valid),
        .m_store_index    (m_store_index),
        .m_store_byte     (m_store_byte),
        .m_status         (m_status),
        .m_message_length (m_message_length)
    );

endmodule
